### rtl/lfpid_pkg.sv
`default_nettype none
package lfpid_pkg;

	localparam int NUM_SENSORS_DEF = 8;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int MAX_SENSORS     = 8;

	localparam int THR_BITS       = 12;
	localparam int GAIN_BITS      = 16;
	localparam int BASE_BITS      = 8;
	localparam int ENA_BITS       = 8;
	localparam int THR_WORD_BITS  = 48;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 48;

	// centroid sum of Q8 weights, magnitude and hit count
	localparam int SUM_BITS  = 13;
	localparam int MAG_BITS  = 12;
	localparam int CNT_BITS  = 4;
	localparam int DIV_STEPS = MAG_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	localparam int ERR_BITS      = 12;
	localparam int DERIV_BITS    = 13;
	localparam int INTEG_BITS    = 15;
	localparam int INTEG_SUM_BITS = 16;
	localparam int INTEGRAL_LIMIT = 12800;
	localparam int WEIGHT_STEP   = 128;

	localparam int OPND_BITS = 17;
	localparam int ACC_BITS  = 34;
	localparam int FRAC_BITS = 16;
	localparam int CORR_BITS = 18;

	localparam int DRIVE_BITS     = 9;
	localparam int DRIVE_LIMIT    = 255;
	localparam int LINE_ERR_BITS  = 11;

	localparam logic [GAIN_BITS-1:0]     GAIN_P_RST = 16'd6400;
	localparam logic [GAIN_BITS-1:0]     GAIN_I_RST = 16'd0;
	localparam logic [GAIN_BITS-1:0]     GAIN_D_RST = 16'd3840;
	localparam logic [BASE_BITS-1:0]     BASE_RST   = 8'd130;
	localparam logic [ENA_BITS-1:0]      ENA_RST    = 8'd254;
	localparam logic [THR_WORD_BITS-1:0] THR_RST    = 48'd137472516098000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_I = 3'd1,
		REG_GAIN_D = 3'd2,
		REG_BASE   = 3'd3,
		REG_ENABLE = 3'd4,
		REG_THR_LO = 3'd5,
		REG_THR_HI = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_PREP,
		S_MUL,
		S_CORR,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_I,
		MUL_D
	} mul_sel_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]     gain_p;
		logic [GAIN_BITS-1:0]     gain_i;
		logic [GAIN_BITS-1:0]     gain_d;
		logic [BASE_BITS-1:0]     base_speed;
		logic [ENA_BITS-1:0]      sensor_enable;
		logic [THR_WORD_BITS-1:0] thr_lo;
		logic [THR_WORD_BITS-1:0] thr_hi;
	} cfg_regs_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     prep;
		logic     mul_step;
		mul_sel_t mul_sel;
		logic     acc_step;
		logic     corr;
		logic     write_out;
	} dp_cmd_t;

	typedef struct packed {
		logic lost;
	} dp_stat_t;

	// Q8 position weight of sensor i out of n
	function automatic logic signed [SUM_BITS-1:0] weight(input int i, input int n);
		return SUM_BITS'((2 * i - (n - 1)) * WEIGHT_STEP);
	endfunction

	function automatic logic signed [DRIVE_BITS-1:0] sat_drive(
		input logic signed [CORR_BITS:0] v
	);
		logic signed [CORR_BITS:0] hi;
		logic signed [CORR_BITS:0] lo;
		hi = (CORR_BITS+1)'(DRIVE_LIMIT);
		lo = -hi;
		if (v > hi) return DRIVE_BITS'(hi);
		if (v < lo) return DRIVE_BITS'(lo);
		return v[DRIVE_BITS-1:0];
	endfunction

	function automatic logic signed [INTEG_BITS-1:0] clamp_integ(
		input logic signed [INTEG_SUM_BITS-1:0] v
	);
		logic signed [INTEG_SUM_BITS-1:0] hi;
		logic signed [INTEG_SUM_BITS-1:0] lo;
		hi = INTEG_SUM_BITS'(INTEGRAL_LIMIT);
		lo = -hi;
		if (v > hi) return INTEG_BITS'(hi);
		if (v < lo) return INTEG_BITS'(lo);
		return v[INTEG_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/lfpid_in_if.sv
`default_nettype none
interface lfpid_in_if #(
	parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_0;
	logic [SAMPLE_BITS-1:0] sample_1;
	logic [SAMPLE_BITS-1:0] sample_2;
	logic [SAMPLE_BITS-1:0] sample_3;
	logic [SAMPLE_BITS-1:0] sample_4;
	logic [SAMPLE_BITS-1:0] sample_5;
	logic [SAMPLE_BITS-1:0] sample_6;
	logic [SAMPLE_BITS-1:0] sample_7;
	logic                   clear_history;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, clear_history,
		input  ready
	);
	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, clear_history,
		output ready
	);
endinterface
`default_nettype wire

### rtl/lfpid_out_if.sv
`default_nettype none
interface lfpid_out_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [lfpid_pkg::DRIVE_BITS-1:0]     left_drive;
	logic signed [lfpid_pkg::DRIVE_BITS-1:0]     right_drive;
	logic                                        line_lost;
	logic signed [lfpid_pkg::LINE_ERR_BITS-1:0]  line_error;

	modport source (
		output valid, left_drive, right_drive, line_lost, line_error,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive, line_lost, line_error,
		output ready
	);
endinterface
`default_nettype wire

### rtl/lfpid_cfg_if.sv
`default_nettype none
interface lfpid_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [lfpid_pkg::CFG_IDX_BITS-1:0]     index;
	logic [lfpid_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/lfpid_cfg.sv
`default_nettype none
module lfpid_cfg (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   wr_valid,
	output logic                                  wr_ready,
	input  wire  [lfpid_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  wire  [lfpid_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output lfpid_pkg::cfg_regs_t                  regs
);

	lfpid_pkg::cfg_regs_t regs_q;

	assign wr_ready = 1'b1;
	assign regs     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p        <= lfpid_pkg::GAIN_P_RST;
			regs_q.gain_i        <= lfpid_pkg::GAIN_I_RST;
			regs_q.gain_d        <= lfpid_pkg::GAIN_D_RST;
			regs_q.base_speed    <= lfpid_pkg::BASE_RST;
			regs_q.sensor_enable <= lfpid_pkg::ENA_RST;
			regs_q.thr_lo        <= lfpid_pkg::THR_RST;
			regs_q.thr_hi        <= lfpid_pkg::THR_RST;
		end else if (wr_valid) begin
			case (lfpid_pkg::cfg_reg_t'(wr_index))
				lfpid_pkg::REG_GAIN_P: begin
					regs_q.gain_p <= wr_data[lfpid_pkg::GAIN_BITS-1:0];
				end
				lfpid_pkg::REG_GAIN_I: begin
					regs_q.gain_i <= wr_data[lfpid_pkg::GAIN_BITS-1:0];
				end
				lfpid_pkg::REG_GAIN_D: begin
					regs_q.gain_d <= wr_data[lfpid_pkg::GAIN_BITS-1:0];
				end
				lfpid_pkg::REG_BASE: begin
					regs_q.base_speed <= wr_data[lfpid_pkg::BASE_BITS-1:0];
				end
				lfpid_pkg::REG_ENABLE: begin
					regs_q.sensor_enable <= wr_data[lfpid_pkg::ENA_BITS-1:0];
				end
				lfpid_pkg::REG_THR_LO: begin
					regs_q.thr_lo <= wr_data[lfpid_pkg::THR_WORD_BITS-1:0];
				end
				lfpid_pkg::REG_THR_HI: begin
					regs_q.thr_hi <= wr_data[lfpid_pkg::THR_WORD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/lfpid_ctrl.sv
`default_nettype none
module lfpid_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  lfpid_pkg::dp_stat_t   stat,
	output lfpid_pkg::dp_cmd_t    cmd
);

	localparam int MUL_CNT_BITS = 2;
	localparam logic [MUL_CNT_BITS-1:0] MUL_LAST = MUL_CNT_BITS'(3);
	localparam logic [lfpid_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
		lfpid_pkg::DIV_CNT_BITS'(lfpid_pkg::DIV_STEPS - 1);

	lfpid_pkg::state_t                   state_q, state_d;
	logic [lfpid_pkg::DIV_CNT_BITS-1:0]  div_cnt_q;
	logic [MUL_CNT_BITS-1:0]             mul_cnt_q;
	logic                                out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfpid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			mul_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.prep) begin
				mul_cnt_q <= '0;
			end else if (state_q == lfpid_pkg::S_MUL) begin
				mul_cnt_q <= mul_cnt_q + 1'b1;
			end
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			lfpid_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lfpid_pkg::S_DIV;
				end
			end
			lfpid_pkg::S_DIV: begin
				if (stat.lost) begin
					state_d = lfpid_pkg::S_FIN;
				end else begin
					cmd.div_step = 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_d = lfpid_pkg::S_PREP;
					end
				end
			end
			lfpid_pkg::S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = lfpid_pkg::S_MUL;
			end
			lfpid_pkg::S_MUL: begin
				// multiply in slot n, accumulate that product in slot n+1
				cmd.mul_step = (mul_cnt_q != MUL_LAST);
				cmd.acc_step = (mul_cnt_q != '0);
				case (mul_cnt_q)
					MUL_CNT_BITS'(0): cmd.mul_sel = lfpid_pkg::MUL_P;
					MUL_CNT_BITS'(1): cmd.mul_sel = lfpid_pkg::MUL_I;
					default:          cmd.mul_sel = lfpid_pkg::MUL_D;
				endcase
				if (mul_cnt_q == MUL_LAST) begin
					state_d = lfpid_pkg::S_CORR;
				end
			end
			lfpid_pkg::S_CORR: begin
				cmd.corr = 1'b1;
				state_d  = lfpid_pkg::S_FIN;
			end
			lfpid_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.write_out = 1'b1;
					state_d       = lfpid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lfpid_pkg::S_IDLE;
			end
		endcase
	end

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten while pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == lfpid_pkg::S_DIV && div_cnt_q == '0))
		else $error("divider not started after accept");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfpid_pkg::S_DIV && !stat.lost && div_cnt_q == DIV_LAST)
		|=> state_q == lfpid_pkg::S_PREP)
		else $error("divider ran past its last step");

endmodule
`default_nettype wire

### rtl/lfpid_dp.sv
`default_nettype none
module lfpid_dp #(
	parameter int NUM_SENSORS = lfpid_pkg::NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  lfpid_pkg::dp_cmd_t                               cmd,
	output lfpid_pkg::dp_stat_t                              stat,
	input  lfpid_pkg::cfg_regs_t                             cfg,
	input  wire  [lfpid_pkg::MAX_SENSORS-1:0][SAMPLE_BITS-1:0] samples,
	input  wire                                              clear_history,
	output logic signed [lfpid_pkg::DRIVE_BITS-1:0]          left_drive,
	output logic signed [lfpid_pkg::DRIVE_BITS-1:0]          right_drive,
	output logic                                             line_lost,
	output logic signed [lfpid_pkg::LINE_ERR_BITS-1:0]       line_error
);

	localparam int WEIGHT_MAX = (NUM_SENSORS - 1) * lfpid_pkg::WEIGHT_STEP;
	localparam int ACC_MSB    = lfpid_pkg::ACC_BITS - 1;

	logic [lfpid_pkg::MAX_SENSORS-1:0][lfpid_pkg::THR_BITS-1:0] thr;

	logic signed [lfpid_pkg::SUM_BITS-1:0]   sum_c;
	logic [lfpid_pkg::CNT_BITS-1:0]          cnt_c;
	logic [lfpid_pkg::SUM_BITS-1:0]          mag_c;

	logic [lfpid_pkg::CNT_BITS-1:0]          cnt_q;
	logic                                    lost_q;
	logic                                    neg_q;
	logic [lfpid_pkg::MAG_BITS-1:0]          quo_q;
	logic [lfpid_pkg::CNT_BITS-1:0]          rem_q;
	logic [lfpid_pkg::CNT_BITS-1:0]          rem_sh;

	logic signed [lfpid_pkg::ERR_BITS-1:0]       err_c;
	logic signed [lfpid_pkg::INTEG_SUM_BITS-1:0] integ_sum_c;
	logic signed [lfpid_pkg::ERR_BITS-1:0]       err_q;
	logic signed [lfpid_pkg::INTEG_BITS-1:0]     integ_new_q;
	logic signed [lfpid_pkg::DERIV_BITS-1:0]     deriv_q;

	logic signed [lfpid_pkg::OPND_BITS-1:0]  opnd_c;
	logic signed [lfpid_pkg::OPND_BITS-1:0]  gain_c;
	logic signed [lfpid_pkg::ACC_BITS-1:0]   prod_q;
	logic signed [lfpid_pkg::ACC_BITS-1:0]   acc_q;
	logic signed [lfpid_pkg::ACC_BITS-1:0]   acc_bias;
	logic signed [lfpid_pkg::ACC_BITS-1:0]   corr_full;
	logic signed [lfpid_pkg::CORR_BITS-1:0]  corr_q;

	logic signed [lfpid_pkg::CORR_BITS:0]    base_s;
	logic signed [lfpid_pkg::DRIVE_BITS-1:0] base_d;

	logic signed [lfpid_pkg::ERR_BITS-1:0]   prev_q;
	logic signed [lfpid_pkg::INTEG_BITS-1:0] integ_q;
	logic signed [lfpid_pkg::ERR_BITS-1:0]   held_q;

	logic signed [lfpid_pkg::DRIVE_BITS-1:0]    left_q;
	logic signed [lfpid_pkg::DRIVE_BITS-1:0]    right_q;
	logic                                       line_lost_q;
	logic signed [lfpid_pkg::LINE_ERR_BITS-1:0] line_error_q;

	assign thr       = {cfg.thr_hi, cfg.thr_lo};
	assign stat.lost = lost_q;

	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign line_lost   = line_lost_q;
	assign line_error  = line_error_q;

	// centroid: weight sum and count of enabled sensors that see the line
	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (cfg.sensor_enable[i] && (32'(samples[i]) < 32'(thr[i]))) begin
				sum_c = sum_c + lfpid_pkg::weight(i, NUM_SENSORS);
				cnt_c = cnt_c + lfpid_pkg::CNT_BITS'(1);
			end
		end
		mag_c = sum_c[lfpid_pkg::SUM_BITS-1] ? -sum_c : sum_c;
	end

	assign rem_sh = {rem_q[lfpid_pkg::CNT_BITS-2:0], quo_q[lfpid_pkg::MAG_BITS-1]};

	always_comb begin
		err_c = neg_q ? -$signed(quo_q) : $signed(quo_q);
		integ_sum_c = lfpid_pkg::INTEG_SUM_BITS'(integ_q)
		            + lfpid_pkg::INTEG_SUM_BITS'(err_c);
	end

	always_comb begin
		case (cmd.mul_sel)
			lfpid_pkg::MUL_P: begin
				opnd_c = lfpid_pkg::OPND_BITS'(err_q);
				gain_c = $signed({1'b0, cfg.gain_p});
			end
			lfpid_pkg::MUL_I: begin
				opnd_c = lfpid_pkg::OPND_BITS'(integ_new_q);
				gain_c = $signed({1'b0, cfg.gain_i});
			end
			default: begin
				opnd_c = lfpid_pkg::OPND_BITS'(deriv_q);
				gain_c = $signed({1'b0, cfg.gain_d});
			end
		endcase
	end

	// divide by 65536 toward zero
	always_comb begin
		acc_bias  = acc_q + $signed({{(lfpid_pkg::ACC_BITS-lfpid_pkg::FRAC_BITS){1'b0}},
		                            {lfpid_pkg::FRAC_BITS{acc_q[ACC_MSB]}}});
		corr_full = acc_bias >>> lfpid_pkg::FRAC_BITS;
	end

	assign base_s = $signed({{(lfpid_pkg::CORR_BITS+1-lfpid_pkg::BASE_BITS){1'b0}},
	                        cfg.base_speed});
	assign base_d = base_s[lfpid_pkg::DRIVE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= cnt_c;
			neg_q <= sum_c[lfpid_pkg::SUM_BITS-1];
			quo_q <= mag_c[lfpid_pkg::MAG_BITS-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= cnt_q) begin
				rem_q <= rem_sh - cnt_q;
				quo_q <= {quo_q[lfpid_pkg::MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[lfpid_pkg::MAG_BITS-2:0], 1'b0};
			end
		end
		if (cmd.prep) begin
			err_q       <= err_c;
			integ_new_q <= lfpid_pkg::clamp_integ(integ_sum_c);
			deriv_q     <= lfpid_pkg::DERIV_BITS'(err_c) - lfpid_pkg::DERIV_BITS'(prev_q);
			acc_q       <= '0;
		end else if (cmd.acc_step) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.mul_step) begin
			prod_q <= opnd_c * gain_c;
		end
		if (cmd.corr) begin
			corr_q <= corr_full[lfpid_pkg::CORR_BITS-1:0];
		end
		if (cmd.write_out) begin
			line_lost_q <= lost_q;
			if (lost_q) begin
				// spin toward the side of the last error
				left_q       <= prev_q[lfpid_pkg::ERR_BITS-1] ? base_d : -base_d;
				right_q      <= prev_q[lfpid_pkg::ERR_BITS-1] ? -base_d : base_d;
				line_error_q <= held_q[lfpid_pkg::LINE_ERR_BITS-1:0];
			end else begin
				left_q       <= lfpid_pkg::sat_drive(base_s - corr_q);
				right_q      <= lfpid_pkg::sat_drive(base_s + corr_q);
				line_error_q <= err_q[lfpid_pkg::LINE_ERR_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_q  <= 1'b0;
			prev_q  <= '0;
			integ_q <= '0;
			held_q  <= '0;
		end else begin
			if (cmd.load) begin
				lost_q <= (cnt_c == '0);
				if (clear_history) begin
					prev_q  <= '0;
					integ_q <= '0;
				end
			end
			if (cmd.write_out && !lost_q) begin
				prev_q  <= err_q;
				integ_q <= integ_new_q;
				held_q  <= err_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= lfpid_pkg::INTEG_BITS'(lfpid_pkg::INTEGRAL_LIMIT))
		&& (integ_q >= -lfpid_pkg::INTEG_BITS'(lfpid_pkg::INTEGRAL_LIMIT)))
		else $error("integral outside its clamp");

	assert property (@(posedge clk) disable iff (!arst_n)
		(held_q <= lfpid_pkg::ERR_BITS'(WEIGHT_MAX))
		&& (held_q >= -lfpid_pkg::ERR_BITS'(WEIGHT_MAX)))
		else $error("line error outside the sensor span");

endmodule
`default_nettype wire

### rtl/line_follow_pid_controller_top.sv
`default_nettype none
// Channel   Kind          Transaction
// samples   valid/ready   eight sensor readings plus clear_history
// drives    valid/ready   left/right drive, line_lost, line_error
// cfg       valid/ready   register write: index, data (always ready)
//
// An item with the line seen goes from accept through 12 restoring-divider
// steps for the centroid mean, one prep step, four slots of the shared 17x17
// multiplier/accumulator, a correction step and the output write. With the
// line lost the block leaves the divider before any step and goes to the write.
// The next item is accepted the cycle after a result is loaded into the
// output register, even if drives has not taken it; a stalled drives channel
// holds the block before it loads the next result. Reset clears the control
// state and PID history and loads the register defaults.
module line_follow_pid_controller_top #(
	parameter int NUM_SENSORS = lfpid_pkg::NUM_SENSORS_DEF,
	parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	lfpid_in_if.sink     samples,
	lfpid_out_if.source  drives,
	lfpid_cfg_if.sink    cfg
);

	lfpid_pkg::cfg_regs_t regs;
	lfpid_pkg::dp_cmd_t   cmd;
	lfpid_pkg::dp_stat_t  stat;

	logic [lfpid_pkg::MAX_SENSORS-1:0][SAMPLE_BITS-1:0] sample_vec;

	assign sample_vec = {samples.sample_7, samples.sample_6, samples.sample_5,
	                     samples.sample_4, samples.sample_3, samples.sample_2,
	                     samples.sample_1, samples.sample_0};

	lfpid_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	lfpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (drives.valid),
		.out_ready (drives.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lfpid_dp #(
		.NUM_SENSORS (NUM_SENSORS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg           (regs),
		.samples       (sample_vec),
		.clear_history (samples.clear_history),
		.left_drive    (drives.left_drive),
		.right_drive   (drives.right_drive),
		.line_lost     (drives.line_lost),
		.line_error    (drives.line_error)
	);

endmodule
`default_nettype wire

### tb/tb_line_follow_pid_controller_top.sv
`timescale 1ns / 1ps
module tb_line_follow_pid_controller_top;
	import lfpid_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int SENSORS = NUM_SENSORS_DEF;
	localparam int SMAX    = (1 << SAMPLE_BITS_DEF) - 1;

	typedef struct packed {
		logic [MAX_SENSORS-1:0][SAMPLE_BITS_DEF-1:0] smp;
		logic                                        clr;
	} sensor_set_t;

	typedef struct packed {
		logic signed [DRIVE_BITS-1:0]    left;
		logic signed [DRIVE_BITS-1:0]    right;
		logic                            lost;
		logic signed [LINE_ERR_BITS-1:0] err;
	} drive_cmd_t;

	logic clk;
	logic arst_n;

	lfpid_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) samples_if ();
	lfpid_out_if drives_if ();
	lfpid_cfg_if cfg_if ();

	line_follow_pid_controller_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.drives  (drives_if),
		.cfg     (cfg_if)
	);

	// shadow copy of the register file
	logic [GAIN_BITS-1:0]     kp;
	logic [GAIN_BITS-1:0]     ki;
	logic [GAIN_BITS-1:0]     kd;
	logic [BASE_BITS-1:0]     base;
	logic [ENA_BITS-1:0]      ena;
	logic [THR_WORD_BITS-1:0] thr_lo;
	logic [THR_WORD_BITS-1:0] thr_hi;

	// shadow copy of the PID history
	logic signed [ERR_BITS-1:0]   last_err;
	logic signed [INTEG_BITS-1:0] err_sum;
	logic signed [ERR_BITS-1:0]   shown_err;

	drive_cmd_t pending_drives[$];

	bit gaps_on      = 1'b0;
	bit samples_held = 1'b0;
	int drive_hold   = 0;
	int mismatches   = 0;
	int stray_drives = 0;
	int sets_sent    = 0;
	int lost_sets    = 0;
	int reg_writes   = 0;
	int drives_seen  = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [THR_BITS-1:0] thr_of(input int i);
		logic [THR_WORD_BITS-1:0] w;
		w = (i < 4) ? thr_lo : thr_hi;
		return w[(i % 4) * THR_BITS +: THR_BITS];
	endfunction

	// centroid + PID step on the shadow state
	function automatic drive_cmd_t steer_step(input sensor_set_t s);
		int         sum;
		int         cnt;
		int         e;
		int         dir;
		int         i;
		longint     integ;
		longint     corr;
		longint     l;
		longint     r;
		drive_cmd_t d;
		sum = 0;
		cnt = 0;
		if (s.clr) begin
			last_err = '0;
			err_sum  = '0;
		end
		for (i = 0; i < SENSORS; i++) begin
			if (ena[i] && s.smp[i] < thr_of(i)) begin
				sum += (2 * i - (SENSORS - 1)) * WEIGHT_STEP;
				cnt++;
			end
		end
		if (cnt == 0) begin
			// spin toward the side the line was last seen on
			dir = (last_err >= 0) ? 1 : -1;
			l = -dir * longint'(base);
			r = dir * longint'(base);
		end else begin
			e = sum / cnt;
			integ = longint'(err_sum) + e;
			if (integ > INTEGRAL_LIMIT)
				integ = INTEGRAL_LIMIT;
			else if (integ < -INTEGRAL_LIMIT)
				integ = -INTEGRAL_LIMIT;
			corr = longint'(kp) * e + longint'(ki) * integ
			     + longint'(kd) * (e - longint'(last_err));
			corr = corr / 65536;
			err_sum   = integ[INTEG_BITS-1:0];
			last_err  = e[ERR_BITS-1:0];
			shown_err = e[ERR_BITS-1:0];
			l = longint'(base) - corr;
			r = longint'(base) + corr;
		end
		if (l > DRIVE_LIMIT) l = DRIVE_LIMIT;
		if (l < -DRIVE_LIMIT) l = -DRIVE_LIMIT;
		if (r > DRIVE_LIMIT) r = DRIVE_LIMIT;
		if (r < -DRIVE_LIMIT) r = -DRIVE_LIMIT;
		d.left  = l[DRIVE_BITS-1:0];
		d.right = r[DRIVE_BITS-1:0];
		d.lost  = (cnt == 0);
		d.err   = shown_err[LINE_ERR_BITS-1:0];
		return d;
	endfunction

	function automatic sensor_set_t pattern_set(input logic [7:0] dark,
		input logic [SAMPLE_BITS_DEF-1:0] lo, input logic [SAMPLE_BITS_DEF-1:0] hi,
		input logic clr);
		sensor_set_t s;
		int          i;
		for (i = 0; i < MAX_SENSORS; i++)
			s.smp[i] = dark[i] ? lo : hi;
		s.clr = clr;
		return s;
	endfunction

	// mostly a plausible line under 1..3 adjacent sensors, some lost, some noise
	function automatic sensor_set_t random_set();
		sensor_set_t          s;
		int                   kind;
		int                   first;
		int                   width;
		int                   i;
		logic [7:0]           dark;
		logic [THR_BITS-1:0]  t;
		kind = $urandom_range(99);
		dark = '0;
		if (kind < 65) begin
			first = $urandom_range(7);
			width = $urandom_range(1, 3);
			for (i = first; i < first + width && i < MAX_SENSORS; i++)
				dark[i] = 1'b1;
		end
		for (i = 0; i < MAX_SENSORS; i++) begin
			t = thr_of(i);
			if (dark[i]) begin
				if (t == 0)
					s.smp[i] = '0;
				else if ($urandom_range(9) == 0)
					s.smp[i] = t - 1'b1;
				else
					s.smp[i] = $urandom_range(0, t - 1);
			end else begin
				if ($urandom_range(9) == 0)
					s.smp[i] = t;
				else
					s.smp[i] = $urandom_range(t, SMAX);
			end
		end
		if (kind >= 80)
			s.smp = {$urandom, $urandom, $urandom};
		s.clr = ($urandom_range(19) == 0);
		return s;
	endfunction

	// valid is left high after a transaction so a back-to-back item needs no toggle
	task automatic send_set(input sensor_set_t s);
		int         gap;
		drive_cmd_t d;
		gap = 0;
		if (gaps_on)
			while ($urandom_range(99) < 14)
				gap++;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid         <= 1'b1;
		samples_if.sample_0      <= s.smp[0];
		samples_if.sample_1      <= s.smp[1];
		samples_if.sample_2      <= s.smp[2];
		samples_if.sample_3      <= s.smp[3];
		samples_if.sample_4      <= s.smp[4];
		samples_if.sample_5      <= s.smp[5];
		samples_if.sample_6      <= s.smp[6];
		samples_if.sample_7      <= s.smp[7];
		samples_if.clear_history <= s.clr;
		do @(posedge clk); while (!samples_if.ready);
		d = steer_step(s);
		pending_drives.push_back(d);
		samples_held = 1'b1;
		sets_sent++;
		if (d.lost)
			lost_sets++;
	endtask

	task automatic wait_drained();
		if (samples_held) begin
			samples_if.valid <= 1'b0;
			samples_held = 1'b0;
		end
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_GAIN_P: kp     = val[GAIN_BITS-1:0];
			REG_GAIN_I: ki     = val[GAIN_BITS-1:0];
			REG_GAIN_D: kd     = val[GAIN_BITS-1:0];
			REG_BASE:   base   = val[BASE_BITS-1:0];
			REG_ENABLE: ena    = val[ENA_BITS-1:0];
			REG_THR_LO: thr_lo = val[THR_WORD_BITS-1:0];
			REG_THR_HI: thr_hi = val[THR_WORD_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	function automatic logic [GAIN_BITS-1:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return $urandom_range(12000);
		endcase
	endfunction

	function automatic logic [THR_WORD_BITS-1:0] pick_thresholds();
		logic [THR_WORD_BITS-1:0] w;
		int                       i;
		for (i = 0; i < 4; i++)
			w[i * THR_BITS +: THR_BITS] = ($urandom_range(9) < 7) ?
				$urandom_range(1000, 3000) : $urandom_range(SMAX);
		return w;
	endfunction

	task automatic randomize_settings();
		write_reg(REG_GAIN_P, pick_gain());
		write_reg(REG_GAIN_I, pick_gain());
		write_reg(REG_GAIN_D, pick_gain());
		write_reg(REG_BASE, $urandom_range(255));
		write_reg(REG_ENABLE, ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom));
		write_reg(REG_THR_LO, pick_thresholds());
		write_reg(REG_THR_HI, pick_thresholds());
	endtask

	task automatic run_random_sets(input int n, input int hold_at, input int pause_at);
		int k;
		for (k = 0; k < n; k++) begin
			// long output stall while samples keep coming
			if (k == hold_at)
				drive_hold = 400;
			if (k == pause_at)
				wait_drained();
			send_set(random_set());
		end
		wait_drained();
	endtask

	task automatic test_reset_defaults();
		send_set(pattern_set(8'h00, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h01, 0, SMAX, 1'b0));   // sensor 0 is disabled at reset
		send_set(pattern_set(8'h80, 1999, 2000, 1'b0)); // just under / at threshold
		send_set(pattern_set(8'h18, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h02, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h00, 0, 2000, 1'b0));   // lost after a negative error
		send_set(pattern_set(8'h00, 0, 2000, 1'b1));   // clear while lost
		wait_drained();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_GAIN_P, '1);
		write_reg(REG_GAIN_I, '1);
		write_reg(REG_GAIN_D, '1);
		write_reg(REG_BASE, '1);
		write_reg(REG_ENABLE, '1);
		write_reg(REG_THR_LO, '1);
		write_reg(REG_THR_HI, '1);
		send_set(pattern_set(8'h01, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h01, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h80, 0, SMAX, 1'b0));
		send_set(pattern_set(8'h00, SMAX - 1, SMAX, 1'b0));
		send_set(pattern_set(8'hFF, SMAX - 1, SMAX, 1'b0));
		send_set(pattern_set(8'h80, 0, SMAX, 1'b1));
		wait_drained();
		// out-of-range index must leave every register alone
		write_reg(REG_UNUSED, '1);
		write_reg(REG_GAIN_P, '0);
		write_reg(REG_GAIN_I, '0);
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_BASE, '0);
		write_reg(REG_ENABLE, '0);
		write_reg(REG_THR_LO, '0);
		write_reg(REG_THR_HI, '0);
		send_set(pattern_set(8'hFF, 0, 0, 1'b0));
		wait_drained();
		write_reg(REG_ENABLE, '1);
		send_set(pattern_set(8'hFF, 0, 0, 1'b0));
		wait_drained();
		write_reg(REG_THR_LO, '1);
		send_set(pattern_set(8'h01, 0, SMAX, 1'b0));
		wait_drained();
	endtask

	task automatic test_integral_clamp();
		int k;
		write_reg(REG_GAIN_I, 16'd2048);
		write_reg(REG_THR_LO, THR_RST);
		write_reg(REG_THR_HI, THR_RST);
		// steady error at the right edge winds the integral into its limit
		for (k = 0; k < 15; k++)
			send_set(pattern_set(8'h80, 0, SMAX, k == 0));
		wait_drained();
	endtask

	task automatic test_random_settings();
		int k;
		gaps_on = 1'b1;
		for (k = 0; k < 2; k++) begin
			randomize_settings();
			run_random_sets(170, -1, -1);
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		randomize_settings();
		run_random_sets(170, -1, -1);
		gaps_on = 1'b1;
	endtask

	task automatic test_drive_backpressure();
		randomize_settings();
		run_random_sets(170, 30, -1);
	endtask

	task automatic test_sender_pause();
		randomize_settings();
		run_random_sets(170, -1, 85);
	endtask

	initial begin
		drives_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (drive_hold > 0) begin
				drives_if.ready <= 1'b0;
				drive_hold--;
			end else if (gaps_on) begin
				drives_if.ready <= ($urandom_range(99) >= 14);
			end else begin
				drives_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_drives
		drive_cmd_t want;
		if (arst_n && drives_if.valid && drives_if.ready) begin
			drives_seen++;
			if (pending_drives.size() == 0) begin
				stray_drives++;
				if (stray_drives + mismatches <= 10)
					$display("%0t: drive transaction with nothing expected", $time);
			end else begin
				want = pending_drives.pop_front();
				if (drives_if.left_drive !== want.left || drives_if.right_drive !== want.right
				    || drives_if.line_lost !== want.lost
				    || drives_if.line_error !== want.err) begin
					mismatches++;
					if (stray_drives + mismatches <= 10)
						$display("%0t: exp L=%0d R=%0d lost=%0b err=%0d, got L=%0d R=%0d lost=%0b err=%0d",
							$time, want.left, want.right, want.lost, want.err,
							drives_if.left_drive, drives_if.right_drive,
							drives_if.line_lost, drives_if.line_error);
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("line_follow_pid_controller_top verification failed");
		$finish;
	end

	initial begin
		arst_n                   = 1'b0;
		samples_if.valid         = 1'b0;
		samples_if.sample_0      = '0;
		samples_if.sample_1      = '0;
		samples_if.sample_2      = '0;
		samples_if.sample_3      = '0;
		samples_if.sample_4      = '0;
		samples_if.sample_5      = '0;
		samples_if.sample_6      = '0;
		samples_if.sample_7      = '0;
		samples_if.clear_history = 1'b0;
		cfg_if.valid             = 1'b0;
		cfg_if.index             = REG_GAIN_P;
		cfg_if.data              = '0;
		kp        = GAIN_P_RST;
		ki        = GAIN_I_RST;
		kd        = GAIN_D_RST;
		base      = BASE_RST;
		ena       = ENA_RST;
		thr_lo    = THR_RST;
		thr_hi    = THR_RST;
		last_err  = '0;
		err_sum   = '0;
		shown_err = '0;
		gaps_on   = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_integral_clamp();
		test_random_settings();
		test_back_to_back();
		test_drive_backpressure();
		test_sender_pause();

		wait_drained();
		repeat (30) @(posedge clk);
		$display("sent %0d sensor sets (%0d with the line lost), checked %0d drive results",
			sets_sent, lost_sets, drives_seen);
		$display("%0d register writes across directed extremes and 5 random settings",
			reg_writes);
		if (mismatches == 0 && stray_drives == 0 && pending_drives.size() == 0)
			$display("line_follow_pid_controller_top verification clean");
		else
			$display("line_follow_pid_controller_top verification failed");
		$finish;
	end

endmodule
